/* design/mcdc_pkg.sv */
// ----------------------------------------------------------------------------
// mcdc_pkg
// Types, constants and saturating arithmetic shared by the clock drift
// corrector modules.
// ----------------------------------------------------------------------------
package mcdc_pkg;

   localparam logic [19:0]        US_PER_S    = 20'd1000000;
   localparam logic [9:0]         US_PER_MS   = 10'd1000;
   localparam logic [31:0]        FREQ_RESET  = 32'd10000000;
   localparam logic [30:0]        LIMIT_RESET = 31'd200000;
   localparam int                 DIV_STEPS   = 63;
   localparam logic signed [63:0] TIME_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] TIME_MIN    = 64'sh8000_0000_0000_0000;

   localparam logic REG_COUNTER_FREQUENCY = 1'b0;
   localparam logic REG_DRIFT_LIMIT       = 1'b1;

   typedef struct packed {
      logic [62:0] fine_count;
      logic [31:0] coarse_ms;
   } req_data_type;

   typedef struct packed {
      logic [62:0] time_us;
      logic        jump_corrected;
      logic        held;
   } rsp_data_type;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_DELTA    = 11'b000_0000_0010,
      ST_MUL_LO   = 11'b000_0000_0100,
      ST_MUL_HI   = 11'b000_0000_1000,
      ST_DIV_INIT = 11'b000_0001_0000,
      ST_DIV      = 11'b000_0010_0000,
      ST_ADD_ADJ  = 11'b000_0100_0000,
      ST_STEP     = 11'b000_1000_0000,
      ST_DRIFT    = 11'b001_0000_0000,
      ST_CORRECT  = 11'b010_0000_0000,
      ST_COMMIT   = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic capture;
      logic delta;
      logic mul_lo;
      logic mul_hi;
      logic div_init;
      logic div_step;
      logic add_adj;
      logic step;
      logic drift;
      logic correct;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } status_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? TIME_MIN : TIME_MAX;
      end
      return s;
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) begin
         return a[63] ? TIME_MIN : TIME_MAX;
      end
      return s;
   endfunction

endpackage

/* design/mcdc_csr.sv */
// ----------------------------------------------------------------------------
// mcdc_csr
// Configuration registers: counter frequency and drift limit.
// ----------------------------------------------------------------------------
module mcdc_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] counter_frequency,
   output logic [30:0] drift_limit_us
);

   logic [31:0] freq_ff;
   logic [31:0] freq_in;
   logic [30:0] limit_ff;
   logic [30:0] limit_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      freq_in  = freq_ff;
      limit_in = limit_ff;
      if (wr_en) begin
         case (paddr[2])
            mcdc_pkg::REG_COUNTER_FREQUENCY: freq_in = pwdata;
            mcdc_pkg::REG_DRIFT_LIMIT:       limit_in = pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         mcdc_pkg::REG_COUNTER_FREQUENCY: prdata = freq_ff;
         mcdc_pkg::REG_DRIFT_LIMIT:       prdata = {1'b0, limit_ff};
         default:                         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= mcdc_pkg::FREQ_RESET;
         limit_ff <= mcdc_pkg::LIMIT_RESET;
      end else begin
         freq_ff  <= freq_in;
         limit_ff <= limit_in;
      end
   end

   assign counter_frequency = freq_ff;
   assign drift_limit_us    = limit_ff;

endmodule

/* design/mcdc_ctrl.sv */
// ----------------------------------------------------------------------------
// mcdc_ctrl
// Sequencer: steps one request through convert, divide, drift check and
// commit.
// ----------------------------------------------------------------------------
module mcdc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mcdc_pkg::status_type status,
   output mcdc_pkg::cmd_type    cmd
);

   mcdc_pkg::state_type state_ff;
   mcdc_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcdc_pkg::ST_IDLE:     if (req_valid) state_in = mcdc_pkg::ST_DELTA;
         mcdc_pkg::ST_DELTA:    state_in = mcdc_pkg::ST_MUL_LO;
         mcdc_pkg::ST_MUL_LO:   state_in = mcdc_pkg::ST_MUL_HI;
         mcdc_pkg::ST_MUL_HI:   state_in = mcdc_pkg::ST_DIV_INIT;
         mcdc_pkg::ST_DIV_INIT: state_in = mcdc_pkg::ST_DIV;
         mcdc_pkg::ST_DIV:      if (status.div_last) state_in = mcdc_pkg::ST_ADD_ADJ;
         mcdc_pkg::ST_ADD_ADJ:  state_in = mcdc_pkg::ST_STEP;
         mcdc_pkg::ST_STEP:     state_in = mcdc_pkg::ST_DRIFT;
         mcdc_pkg::ST_DRIFT:    state_in = mcdc_pkg::ST_CORRECT;
         mcdc_pkg::ST_CORRECT:  state_in = mcdc_pkg::ST_COMMIT;
         mcdc_pkg::ST_COMMIT:   if (status.out_free) state_in = mcdc_pkg::ST_IDLE;
         default:               state_in = mcdc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcdc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall    = (state_ff != mcdc_pkg::ST_IDLE);
   assign cmd.capture  = (state_ff == mcdc_pkg::ST_IDLE) && req_valid;
   assign cmd.delta    = (state_ff == mcdc_pkg::ST_DELTA);
   assign cmd.mul_lo   = (state_ff == mcdc_pkg::ST_MUL_LO);
   assign cmd.mul_hi   = (state_ff == mcdc_pkg::ST_MUL_HI);
   assign cmd.div_init = (state_ff == mcdc_pkg::ST_DIV_INIT);
   assign cmd.div_step = (state_ff == mcdc_pkg::ST_DIV);
   assign cmd.add_adj  = (state_ff == mcdc_pkg::ST_ADD_ADJ);
   assign cmd.step     = (state_ff == mcdc_pkg::ST_STEP);
   assign cmd.drift    = (state_ff == mcdc_pkg::ST_DRIFT);
   assign cmd.correct  = (state_ff == mcdc_pkg::ST_CORRECT);
   assign cmd.commit   = (state_ff == mcdc_pkg::ST_COMMIT) && status.out_free;

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == mcdc_pkg::ST_DIV && status.div_last |=> state_ff == mcdc_pkg::ST_ADD_ADJ)
      else $error("divider did not hand over to adjustment add");

   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> state_ff == mcdc_pkg::ST_IDLE && !req_stall)
      else $error("sequencer not ready after commit");

endmodule

/* design/mcdc_dp.sv */
// ----------------------------------------------------------------------------
// mcdc_dp
// Datapath: counter-to-microsecond conversion with a two-pass multiply and a
// restoring divider, drift correction, monotonic hold and result register.
// ----------------------------------------------------------------------------
module mcdc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  mcdc_pkg::cmd_type      cmd,
   output mcdc_pkg::status_type   status,
   input  mcdc_pkg::req_data_type req_data,
   input  logic [31:0]            counter_frequency,
   input  logic [30:0]            drift_limit_us,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mcdc_pkg::rsp_data_type rsp_data
);

   // sample and persistent state
   logic [62:0]        fine_ff;
   logic [31:0]        coarse_ff;
   logic               started_ff;
   logic [62:0]        origin_ff;
   logic [31:0]        last_tick_ff;
   logic signed [63:0] last_time_ff;
   logic signed [63:0] adj_ff;

   // conversion
   logic [62:0] delta_ff;
   logic [41:0] tick_us_ff;
   logic [82:0] prod_ff;
   logic [31:0] div_ff;
   logic [31:0] rem_ff;
   logic [62:0] quo_ff;
   logic [5:0]  cnt_ff;
   logic        sat_ff;

   // drift check
   logic signed [63:0] now_ff;
   logic signed [63:0] step_ff;
   logic signed [63:0] drift_ff;
   logic               jump_ff;

   logic                   rsp_valid_ff;
   mcdc_pkg::rsp_data_type rsp_ff;

   logic [31:0]        mul_a;
   logic [51:0]        mul_p;
   logic [31:0]        tick_gap;
   logic [31:0]        divisor;
   logic [32:0]        trial;
   logic [32:0]        trial_sub;
   logic               trial_ge;
   logic signed [63:0] quotient;
   logic signed [63:0] limit_pos;
   logic signed [63:0] limit_neg;
   logic               big;
   logic               held;

   assign mul_a     = cmd.mul_hi ? {1'b0, delta_ff[62:32]} : delta_ff[31:0];
   assign mul_p     = 52'(mul_a) * 52'(mcdc_pkg::US_PER_S);
   assign tick_gap  = coarse_ff - last_tick_ff;
   assign divisor   = (counter_frequency == 32'd0) ? 32'd1 : counter_frequency;
   assign trial     = {rem_ff, quo_ff[62]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign trial_ge  = (trial >= {1'b0, div_ff});
   assign quotient  = sat_ff ? mcdc_pkg::TIME_MAX : $signed({1'b0, quo_ff});
   assign limit_pos = $signed({33'd0, drift_limit_us});
   assign limit_neg = -limit_pos;
   assign big       = (drift_ff > limit_pos) || (drift_ff < limit_neg);
   assign held      = (now_ff < last_time_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         origin_ff    <= '0;
         last_tick_ff <= '0;
         last_time_ff <= '0;
         adj_ff       <= '0;
      end else begin
         if (cmd.capture && !started_ff) begin
            started_ff   <= 1'b1;
            origin_ff    <= req_data.fine_count;
            last_tick_ff <= req_data.coarse_ms;
            last_time_ff <= '0;
         end
         if (cmd.correct && big) begin
            adj_ff <= mcdc_pkg::sat_add(adj_ff, drift_ff);
         end
         if (cmd.commit && !held) begin
            last_tick_ff <= coarse_ff;
            last_time_ff <= now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         fine_ff   <= req_data.fine_count;
         coarse_ff <= req_data.coarse_ms;
      end
      if (cmd.delta) begin
         delta_ff   <= (fine_ff >= origin_ff) ? (fine_ff - origin_ff) : '0;
         tick_us_ff <= 42'(tick_gap) * 42'(mcdc_pkg::US_PER_MS);
      end
      if (cmd.mul_lo) begin
         prod_ff <= 83'(mul_p);
      end
      if (cmd.mul_hi) begin
         prod_ff <= prod_ff + (83'(mul_p) << 32);
      end
      if (cmd.div_init) begin
         div_ff <= divisor;
         sat_ff <= ({12'd0, prod_ff[82:63]} >= divisor);
         rem_ff <= {12'd0, prod_ff[82:63]};
         quo_ff <= prod_ff[62:0];
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= trial_ge ? trial_sub[31:0] : trial[31:0];
         quo_ff <= {quo_ff[61:0], trial_ge};
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.add_adj) begin
         now_ff <= mcdc_pkg::sat_add(quotient, adj_ff);
      end
      if (cmd.step) begin
         step_ff <= mcdc_pkg::sat_sub(now_ff, last_time_ff);
      end
      if (cmd.drift) begin
         drift_ff <= mcdc_pkg::sat_sub($signed({22'd0, tick_us_ff}), step_ff);
      end
      if (cmd.correct) begin
         jump_ff <= big;
         if (big) begin
            now_ff <= mcdc_pkg::sat_add(now_ff, drift_ff);
         end
      end
      if (cmd.commit) begin
         rsp_ff.time_us        <= held ? last_time_ff[62:0] : now_ff[62:0];
         rsp_ff.jump_corrected <= jump_ff;
         rsp_ff.held           <= held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.div_last = (cnt_ff == 6'(mcdc_pkg::DIV_STEPS - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   a_time_monotonic: assert property (@(posedge clock)
      !reset && !$past(reset) |-> last_time_ff >= $past(last_time_ff))
      else $error("last output time went backward");

   a_commit_output: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && rsp_ff.time_us == last_time_ff[62:0])
      else $error("result time differs from committed time");

   a_held_keeps_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && held |=> $stable(last_tick_ff) && rsp_ff.held)
      else $error("held request updated the last tick");

endmodule

/* design/monotonic_clock_drift_corrector_top.sv */
// ----------------------------------------------------------------------------
// monotonic_clock_drift_corrector_top
// Converts fine counter samples to monotonic microseconds, corrected against
// a coarse millisecond tick.
// ----------------------------------------------------------------------------
// One request is processed at a time: a new request is accepted only when the
// sequencer has returned to idle after the previous commit. Most of the work
// is the 63-step restoring divider that turns (fine - origin) * 1000000 into
// microseconds by the counter frequency; the multiply takes two passes of a
// 32 x 20 bit multiplier, and the drift check runs single-add steps for the
// adjustment add, step, drift and correction. The result waits in an output
// register; while it waits, the next request runs up to its last step and
// holds there until the previous result has been taken or is being taken.
module monotonic_clock_drift_corrector_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mcdc_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mcdc_pkg::rsp_data_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   mcdc_pkg::cmd_type    cmd;
   mcdc_pkg::status_type status;
   logic [31:0]          counter_frequency;
   logic [30:0]          drift_limit_us;

   mcdc_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .counter_frequency (counter_frequency),
      .drift_limit_us    (drift_limit_us)
   );

   mcdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mcdc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_data          (req_data),
      .counter_frequency (counter_frequency),
      .drift_limit_us    (drift_limit_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data)
   );

endmodule

/* tb/monotonic_clock_drift_corrector_top_tb.sv */
// ----------------------------------------------------------------------------
// monotonic_clock_drift_corrector_top_tb
// Drives fine counter / coarse tick samples into the drift corrector and
// checks every result against a cycle-free predictor of the corrected time.
// A directed table covers the origin sample, field extremes, coarse wrap,
// backward counters, zero frequency, saturation and zero limit. Random phases
// follow, each under its own register setting, with random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module monotonic_clock_drift_corrector_top_tb;

   localparam int WATCHDOG_CYCLES = 4000;
   localparam int DIRECTED_COUNT  = 22;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_ITEMS     = 150;
   localparam int DRAIN_CYCLES    = 100;
   localparam mcdc_pkg::rsp_data_type NO_EXPECT = '0;

   typedef enum logic { ROW_SAMPLE, ROW_CONFIG } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [62:0]            fine_count;
      logic [31:0]            coarse_ms;
      logic                   typed;
      mcdc_pkg::rsp_data_type expected;
      logic                   reg_sel;
      logic [31:0]            value;
   } directed_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   mcdc_pkg::req_data_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   mcdc_pkg::rsp_data_type rsp_data;
   logic                   psel      = 1'b0;
   logic                   penable   = 1'b0;
   logic                   pwrite    = 1'b0;
   logic [2:0]             paddr     = '0;
   logic [31:0]            pwdata    = '0;
   logic [31:0]            prdata;
   logic                   pready;

   // predictor state and register copies
   logic [31:0]        freq_setting  = mcdc_pkg::FREQ_RESET;
   logic [30:0]        limit_setting = mcdc_pkg::LIMIT_RESET;
   logic               seen_first    = 1'b0;
   logic [63:0]        base_count    = '0;
   logic [31:0]        prev_tick_ms  = '0;
   logic signed [63:0] prev_out_us   = '0;
   logic signed [63:0] offset_us     = '0;

   mcdc_pkg::rsp_data_type expected_times [$];
   mcdc_pkg::rsp_data_type expected_head;
   int           error_count = 0;
   int           idle_cycles = 0;
   int unsigned  stall_left  = 0;
   logic         took_rsp;
   logic         req_quiet   = 1'b0;
   logic         rsp_quiet   = 1'b0;
   logic [62:0]  nominal_fine;
   logic [31:0]  nominal_ms;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{ROW_SAMPLE, 63'h100, 32'hFFFF_FF00, 1'b1, '{63'd0, 1'b0, 1'b0},
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'd10000256, 32'h0000_02E8, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'd1010000256, 32'h0000_06D0, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'h0, 32'h0000_0AB8, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'h5555_5555_5555_5555, 32'h5555_5555, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'h2AAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_CONFIG, 63'h0, 32'h0, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'h7FFF_FFFF_FFFF_FFFF, 32'h0, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'h100, 32'h1, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_CONFIG, 63'h0, 32'h0, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_DRIFT_LIMIT, 32'd0},
      '{ROW_CONFIG, 63'h0, 32'h0, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd1},
      '{ROW_SAMPLE, 63'h200, 32'h2, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'h200, 32'h2, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_CONFIG, 63'h0, 32'h0, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'hFFFF_FFFF},
      '{ROW_CONFIG, 63'h0, 32'h0, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_DRIFT_LIMIT, 32'h7FFF_FFFF},
      '{ROW_SAMPLE, 63'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_CONFIG, 63'h0, 32'h0, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd1000000},
      '{ROW_CONFIG, 63'h0, 32'h0, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_DRIFT_LIMIT, 32'd1000},
      '{ROW_SAMPLE, 63'h1_0000_0000, 32'h8000_1000, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0},
      '{ROW_SAMPLE, 63'h1_0010_0000, 32'h8000_1400, 1'b0, NO_EXPECT,
        mcdc_pkg::REG_COUNTER_FREQUENCY, 32'd0}
   };

   monotonic_clock_drift_corrector_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
      logic [64:0] sum;
      sum = {a[63], a} + {b[63], b};
      if (sum[64] != sum[63]) begin
         return sum[64] ? mcdc_pkg::TIME_MIN : mcdc_pkg::TIME_MAX;
      end
      return sum[63:0];
   endfunction

   function automatic logic signed [63:0] sub_clamped(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
      logic [64:0] diff;
      diff = {a[63], a} - {b[63], b};
      if (diff[64] != diff[63]) begin
         return diff[64] ? mcdc_pkg::TIME_MIN : mcdc_pkg::TIME_MAX;
      end
      return diff[63:0];
   endfunction

   function automatic logic signed [63:0] fine_to_us(input logic [63:0] elapsed,
                                                     input logic [31:0] freq);
      logic [127:0] divisor;
      logic [127:0] quotient;
      divisor  = (freq == 32'd0) ? 128'd1 : {96'd0, freq};
      quotient = ({64'd0, elapsed} * 128'd1000000) / divisor;
      if (quotient > 128'h7FFF_FFFF_FFFF_FFFF) begin
         return mcdc_pkg::TIME_MAX;
      end
      return quotient[63:0];
   endfunction

   function automatic mcdc_pkg::rsp_data_type predict_time(
      input mcdc_pkg::req_data_type sample);
      logic [63:0]            fine;
      logic [63:0]            elapsed;
      logic [31:0]            tick_gap;
      logic signed [63:0]     now_us;
      logic signed [63:0]     tick_us;
      logic signed [63:0]     drift_us;
      logic signed [63:0]     limit_us;
      mcdc_pkg::rsp_data_type result;
      fine = {1'b0, sample.fine_count};
      if (!seen_first) begin
         seen_first   = 1'b1;
         base_count   = fine;
         prev_tick_ms = sample.coarse_ms;
         prev_out_us  = '0;
      end
      elapsed  = (fine >= base_count) ? fine - base_count : 64'd0;
      now_us   = add_clamped(fine_to_us(elapsed, freq_setting), offset_us);
      tick_gap = sample.coarse_ms - prev_tick_ms;
      tick_us  = $signed({32'd0, tick_gap} * 64'd1000);
      drift_us = sub_clamped(tick_us, sub_clamped(now_us, prev_out_us));
      limit_us = $signed({33'd0, limit_setting});
      result   = '0;
      if (drift_us > limit_us || drift_us < -limit_us) begin
         offset_us             = add_clamped(offset_us, drift_us);
         now_us                = add_clamped(now_us, drift_us);
         result.jump_corrected = 1'b1;
      end
      if (now_us >= prev_out_us) begin
         prev_tick_ms = sample.coarse_ms;
         prev_out_us  = now_us;
      end else begin
         result.held = 1'b1;
      end
      result.time_us = prev_out_us[62:0];
      return result;
   endfunction

   // mostly plausible counter/tick pairs, with jumps, backward steps, wraps and noise
   function automatic mcdc_pkg::req_data_type next_sample();
      mcdc_pkg::req_data_type sample;
      int unsigned            pick;
      int unsigned            step_ms;
      logic [63:0]            ticks;
      pick    = $urandom_range(0, 99);
      step_ms = $urandom_range(0, (pick < 50) ? 300 : 5000);
      ticks   = (64'(step_ms) * 64'(freq_setting)) / 64'd1000;
      if (pick < 70) begin
         nominal_ms   += step_ms;
         nominal_fine += 63'(ticks + 64'($urandom() % (freq_setting / 20 + 1)));
      end else if (pick < 78) begin
         nominal_ms   += step_ms;
         nominal_fine += 63'(ticks * $urandom_range(2, 50));
      end else if (pick < 84) begin
         nominal_ms   += $urandom();
         nominal_fine += 63'(ticks);
      end else if (pick < 90) begin
         nominal_ms   += step_ms;
         nominal_fine -= nominal_fine >> $urandom_range(1, 8);
      end else if (pick < 94) begin
         nominal_ms    = 32'hFFFF_FFFF - $urandom_range(0, 3000);
         nominal_fine += 63'(ticks);
      end else begin
         nominal_ms    = $urandom();
         nominal_fine  = 63'({$urandom(), $urandom()});
      end
      sample.fine_count = nominal_fine;
      sample.coarse_ms  = nominal_ms;
      return sample;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_request(input mcdc_pkg::req_data_type sample, input logic typed,
                               input mcdc_pkg::rsp_data_type typed_rsp);
      int unsigned            gap;
      mcdc_pkg::rsp_data_type predicted;
      gap = req_quiet ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_time(sample);
      expected_times.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_times.size() != 0) @(posedge clock);
   endtask

   // write, then read back through a second transfer
   task automatic write_register(input logic reg_sel, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_sel == mcdc_pkg::REG_COUNTER_FREQUENCY) begin
         freq_setting = value;
      end else begin
         limit_setting = value[30:0];
      end
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_sel == mcdc_pkg::REG_COUNTER_FREQUENCY) begin
         if (prdata !== freq_setting) begin
            report_mismatch("counter_frequency readback", 64'(prdata), 64'(freq_setting));
         end
      end else if (prdata[30:0] !== limit_setting) begin
         report_mismatch("drift_limit_us readback", 64'(prdata[30:0]),
                         64'(limit_setting));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         took_rsp = rsp_valid && !rsp_stall;
         if (took_rsp) begin
            if (expected_times.size() == 0) begin
               report_mismatch("result with no request pending", 64'(rsp_data.time_us),
                               64'd0);
            end else begin
               expected_head = expected_times.pop_front();
               if (rsp_data.time_us !== expected_head.time_us) begin
                  report_mismatch("time_us", 64'(rsp_data.time_us),
                                  64'(expected_head.time_us));
               end
               if (rsp_data.jump_corrected !== expected_head.jump_corrected) begin
                  report_mismatch("jump_corrected", 64'(rsp_data.jump_corrected),
                                  64'(expected_head.jump_corrected));
               end
               if (rsp_data.held !== expected_head.held) begin
                  report_mismatch("held", 64'(rsp_data.held), 64'(expected_head.held));
               end
            end
            stall_left = rsp_quiet ? 0 : $urandom_range(0, 15);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
         if (took_rsp || (req_valid && !req_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [31:0]            freq_value;
      logic [30:0]            limit_value;
      directed_row_type       row;
      mcdc_pkg::req_data_type sample;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_CONFIG) begin
            drain_results();
            write_register(row.reg_sel, row.value);
         end else begin
            sample.fine_count = row.fine_count;
            sample.coarse_ms  = row.coarse_ms;
            send_request(sample, row.typed, row.expected);
         end
      end
      nominal_fine = directed_rows[DIRECTED_COUNT - 1].fine_count;
      nominal_ms   = directed_rows[DIRECTED_COUNT - 1].coarse_ms;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               freq_value  = mcdc_pkg::FREQ_RESET;
               limit_value = mcdc_pkg::LIMIT_RESET;
            end
            1: begin
               freq_value  = 32'd1;
               limit_value = 31'd0;
            end
            2: begin
               freq_value  = 32'hFFFF_FFFF;
               limit_value = 31'h7FFF_FFFF;
            end
            3: begin
               freq_value  = 32'd1000000;
               limit_value = 31'd1;
            end
            4: begin
               freq_value  = 32'd0;
               limit_value = 31'd1000;
            end
            6: begin
               freq_value  = 32'd3579545;
               limit_value = 31'd50000;
            end
            7: begin
               freq_value  = $urandom();
               limit_value = 31'($urandom_range(0, 2000000));
            end
            default: begin
               freq_value  = $urandom();
               limit_value = 31'($urandom());
            end
         endcase
         drain_results();
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         write_register(mcdc_pkg::REG_COUNTER_FREQUENCY, freq_value);
         write_register(mcdc_pkg::REG_DRIFT_LIMIT, {1'b0, limit_value});
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // in phase 3, hold off once mid-phase until the pipeline is empty
            if (phase == 3 && n == PHASE_ITEMS / 2) begin
               drain_results();
            end
            send_request(next_sample(), 1'b0, NO_EXPECT);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_times.size() != 0) begin
         report_mismatch("results never returned", 64'(expected_times.size()), 64'd0);
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
